FILE: hw/rtl/egr_pkg.sv
`default_nettype none
package egr_pkg;

    localparam int ANGLE_FRACTION_BITS_DEF = 20;
    localparam int CORDIC_STAGES_DEF       = 24;

    localparam int LON_IN_W  = 30;
    localparam int LAT_W     = 28;
    localparam int LON_OUT_W = 29;

    // CORDIC datapath width and square-root step count (bits of a Q30 root)
    localparam int VW         = 34;
    localparam int SQRT_STEPS = 31;
    localparam int SQW        = 62;

    localparam longint INV_GAIN_Q30 = 64'd652032874;

    // floor(u / 45) = (u * RECIP_45) >> RECIP_SHIFT for u < 2^30
    localparam int     Den45       = 45;
    localparam longint RECIP_45    = 64'd1527099484;
    localparam int     RECIP_SHIFT = 36;
    // 2^29 = 45 * OFFS_Q + OFFS_R
    localparam int     OFFS_Q      = 11930464;
    localparam int     OFFS_R      = 32;

    localparam longint unsigned PI_Q60    = 64'h3243F6A8885A308D;
    localparam longint unsigned DEC_SCALE = 64'd1000000000000;

    localparam longint MAT_DEC [9] = '{
        -64'sd54875539726,  -64'sd873437108010, -64'sd483834985808,
         64'sd494109453312, -64'sd444829589425,  64'sd746982251810,
        -64'sd867666135858, -64'sd198076386122,  64'sd455983795705
    };

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] a;
    } t_cvec;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] r;
    } t_sqrt;

    typedef logic [17:0]        t_frac_tab [45];
    typedef logic signed [31:0] t_mat [9];

    // restoring long division, elaboration only
    function automatic longint unsigned egr_udiv(input longint unsigned n,
                                                 input longint unsigned d);
        longint unsigned r;
        longint unsigned q;
        r = 0;
        q = 0;
        for (int k = 63; k >= 0; k--) begin
            r = (r << 1) | longint'(n[k]);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // round(num * 2^bits / den), num < den
    function automatic longint unsigned egr_frac_div(input longint unsigned num,
                                                     input longint unsigned den,
                                                     input int bits);
        longint unsigned r;
        longint unsigned q;
        r = num;
        q = 0;
        for (int k = 0; k <= bits; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    // arctan(2^-i) in turns * 2^32
    function automatic longint egr_atan(input int i);
        longint unsigned acc;
        longint unsigned term;
        int e;
        acc = 0;
        if (i == 0) return 64'sd1 << 29;
        for (int k = 0; k < 63; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = egr_udiv(64'd1 << (62 - e), longint'(2 * k + 1));
                if (k % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
        end
        return longint'(egr_frac_div(acc, PI_Q60, 29));
    endfunction

    function automatic t_mat egr_mat_tab(input bit transpose);
        t_mat m;
        longint dv;
        longint q;
        int src;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                src = transpose ? c * 3 + r : r * 3 + c;
                dv  = MAT_DEC[src];
                q   = longint'(egr_frac_div(dv < 0 ? -dv : dv, DEC_SCALE, 30));
                m[r * 3 + c] = 32'(dv < 0 ? -q : q);
            end
        end
        return m;
    endfunction

    // floor(b * 2^s / 45) for every remainder b
    function automatic t_frac_tab egr_frac_tab(input int s);
        t_frac_tab t;
        for (int b = 0; b < 45; b++) begin
            t[b] = 18'((longint'(b) << s) / Den45);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/egr_in_if.sv
`default_nettype none
interface egr_in_if;
    import egr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [LON_IN_W-1:0] lon_in;
    logic signed [LAT_W-1:0]    lat_in;

    modport source(output valid, mode, lon_in, lat_in, input ready);
    modport sink(input valid, mode, lon_in, lat_in, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/egr_out_if.sv
`default_nettype none
interface egr_out_if;
    import egr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [LON_OUT_W-1:0]    lon_out;
    logic signed [LAT_W-1:0] lat_out;

    modport source(output valid, lon_out, lat_out, input ready);
    modport sink(input valid, lon_out, lat_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/equatorial_galactic_rotation_unit.sv
`default_nettype none
// Channel | Dir | Payload                       | Handshake
// i_in    | in  | mode, lon_in[30], lat_in[28]  | valid/ready
// o_out   | out | lon_out[29], lat_out[28]      | valid/ready
//
// One request accepted per cycle while the output is not stalled; each request
// passes a sine/cosine CORDIC cell chain, a 31-cell square-root chain, an atan2
// CORDIC cell chain and glue. The single-issue cell chains take one request per clock.
// Reset (sync, active low) clears the valid line only; no sweep needed.
// A stalled output freezes the whole chain; i_in.ready drops only while
// the output register holds a result that is not taken.
module equatorial_galactic_rotation_unit #(
    parameter int ANGLE_FRACTION_BITS = egr_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_STAGES       = egr_pkg::CORDIC_STAGES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    egr_in_if.sink          i_in,
    egr_out_if.source       o_out
);
    import egr_pkg::*;

    localparam int S        = CORDIC_STAGES;
    localparam int SHIFT_IN = 30 - ANGLE_FRACTION_BITS;
    localparam int SH_OUT   = 32 - ANGLE_FRACTION_BITS;
    localparam int L        = 2 * S + SQRT_STEPS + 10;

    localparam t_frac_tab FRAC_TAB = egr_frac_tab(SHIFT_IN);
    localparam t_mat      MAT_F    = egr_mat_tab(1'b0);
    localparam t_mat      MAT_T    = egr_mat_tab(1'b1);

    localparam logic [40:0] FULL     = 41'(64'd360 << ANGLE_FRACTION_BITS);
    localparam logic [28:0] FULL29   = FULL[28:0];
    localparam logic [40:0] HALF_LON = 41'(1) << (SH_OUT - 1);
    localparam logic [42:0] HALF_LAT = 43'(1) << (SH_OUT - 1);
    localparam logic [SQW-1:0] ONE_Q60 = SQW'(1) << 60;

    // Q60 -> Q30, round half up
    function automatic logic signed [VW-1:0] rnd_q30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + 66'sd536870912) >>> 30;
        return t[VW-1:0];
    endfunction

    logic         adv;
    logic [L-1:0] r_vld;

    assign adv         = !r_vld[L-1] || o_out.ready;
    assign i_in.ready  = adv;
    assign o_out.valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // ---------------- angle to turns: floor division by 45 ----------------
    logic signed [29:0] n_ext [2];
    logic [29:0]        n_u   [2];
    logic [60:0]        n_mul [2];
    logic [24:0]        r_q1  [2];
    logic [29:0]        r_u1  [2];
    logic               r_mode1, r_mode2, r_mode3;

    assign n_ext[0] = i_in.lon_in;
    assign n_ext[1] = 30'(i_in.lat_in);

    logic [5:0]         n_bp  [2];
    logic               n_lt  [2];
    logic signed [25:0] r_a2  [2];
    logic [5:0]         r_b2  [2];

    logic signed [45:0] n_p33 [2];
    logic [31:0]        n_p   [2];
    logic               n_neg [2];
    logic [31:0]        n_pf  [2];
    logic signed [VW-1:0] r_ang3 [2];
    logic [1:0]         r_neg3;

    for (genvar j = 0; j < 2; j++) begin : g_front
        // offset by 2^29 so the division sees an unsigned value
        assign n_u[j]   = {~n_ext[j][29], n_ext[j][28:0]};
        assign n_mul[j] = 61'(n_u[j]) * 61'(RECIP_45);
        assign n_bp[j]  = 6'(r_u1[j] - 30'(r_q1[j] * 30'(Den45)));
        assign n_lt[j]  = n_bp[j] < 6'(OFFS_R);
        assign n_p33[j] = (46'(r_a2[j]) <<< SHIFT_IN) + 46'(FRAC_TAB[r_b2[j]]) + 46'sd1;
        assign n_p[j]   = n_p33[j][32:1];
        // quadrants 1 and 2 fold by half a turn
        assign n_neg[j] = n_p[j][31] ^ n_p[j][30];
        assign n_pf[j]  = {n_p[j][31] ^ n_neg[j], n_p[j][30:0]};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_q1[j] <= n_mul[j][RECIP_SHIFT+24:RECIP_SHIFT];
                r_u1[j] <= n_u[j];
                r_a2[j] <= 26'(signed'({1'b0, r_q1[j]})) - 26'sd11930464
                           - 26'(signed'({1'b0, n_lt[j]}));
                r_b2[j] <= n_lt[j] ? n_bp[j] + 6'(Den45 - OFFS_R) : n_bp[j] - 6'(OFFS_R);
                r_ang3[j] <= VW'(signed'(n_pf[j]));
                r_neg3[j] <= n_neg[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mode1 <= i_in.mode;
            r_mode2 <= r_mode1;
            r_mode3 <= r_mode2;
        end
    end

    // ---------------- sine / cosine cell chains ----------------
    t_cvec      w_rot [2][S+1];
    logic       r_rmode [S];
    logic [1:0] r_rneg  [S];

    for (genvar j = 0; j < 2; j++) begin : g_rot
        assign w_rot[j][0].x = VW'(INV_GAIN_Q30);
        assign w_rot[j][0].y = '0;
        assign w_rot[j][0].a = r_ang3[j];
        for (genvar i = 0; i < S; i++) begin : g_cell
            egr_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_cell (
                .i_clk(i_clk), .i_en(adv), .i_v(w_rot[j][i]), .o_v(w_rot[j][i+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rmode[0] <= r_mode3;
            r_rneg[0]  <= r_neg3;
            for (int i = 1; i < S; i++) begin
                r_rmode[i] <= r_rmode[i-1];
                r_rneg[i]  <= r_rneg[i-1];
            end
        end
    end

    // ---------------- unit vector and rotation ----------------
    logic signed [31:0] n_cl, n_sl, n_cb, n_sb;
    logic signed [63:0] r_pcc, r_psc;
    logic signed [31:0] r_sb4;
    logic               r_mode4, r_mode5;
    logic signed [31:0] r_v1 [3];
    logic signed [63:0] r_prod [9];
    logic signed [VW-1:0] r_v2 [3];

    assign n_cl = r_rneg[S-1][0] ? -w_rot[0][S].x[31:0] : w_rot[0][S].x[31:0];
    assign n_sl = r_rneg[S-1][0] ? -w_rot[0][S].y[31:0] : w_rot[0][S].y[31:0];
    assign n_cb = r_rneg[S-1][1] ? -w_rot[1][S].x[31:0] : w_rot[1][S].x[31:0];
    assign n_sb = r_rneg[S-1][1] ? -w_rot[1][S].y[31:0] : w_rot[1][S].y[31:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pcc   <= n_cl * n_cb;
            r_psc   <= n_sl * n_cb;
            r_sb4   <= n_sb;
            r_mode4 <= r_rmode[S-1];
            r_v1[0] <= 32'(rnd_q30(66'(r_pcc)));
            r_v1[1] <= 32'(rnd_q30(66'(r_psc)));
            r_v1[2] <= r_sb4;
            r_mode5 <= r_mode4;
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= (r_mode5 ? MAT_T[k] : MAT_F[k]) * r_v1[k % 3];
            end
            for (int r = 0; r < 3; r++) begin
                r_v2[r] <= rnd_q30(66'(r_prod[3*r]) + 66'(r_prod[3*r+1])
                                   + 66'(r_prod[3*r+2]));
            end
        end
    end

    // ---------------- pole, half-turn fold, clamp, z squared ----------------
    logic signed [31:0] n_zc;
    logic               r_pole8, r_base8;
    logic signed [VW-1:0] r_lx8, r_ly8;
    logic signed [31:0] r_z8;
    logic [63:0]        r_zz8;

    always_comb begin
        if (r_v2[2] > VW'(64'sd1073741824)) n_zc = 32'sd1073741824;
        else if (r_v2[2] < -VW'(64'sd1073741824)) n_zc = -32'sd1073741824;
        else n_zc = r_v2[2][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pole8 <= (r_v2[0] == '0) && (r_v2[1] == '0);
            r_base8 <= r_v2[0][VW-1];
            r_lx8   <= r_v2[0][VW-1] ? -r_v2[0] : r_v2[0];
            r_ly8   <= r_v2[0][VW-1] ? -r_v2[1] : r_v2[1];
            r_z8    <= n_zc;
            r_zz8   <= 64'(n_zc) * 64'(n_zc);
        end
    end

    // ---------------- square-root chain: sqrt(1 - z^2) ----------------
    t_sqrt              w_sq [SQRT_STEPS+1];
    logic               r_qpole [SQRT_STEPS];
    logic               r_qbase [SQRT_STEPS];
    logic signed [VW-1:0] r_qlx [SQRT_STEPS];
    logic signed [VW-1:0] r_qly [SQRT_STEPS];
    logic signed [31:0] r_qz    [SQRT_STEPS];

    assign w_sq[0].v = ONE_Q60 - r_zz8[SQW-1:0];
    assign w_sq[0].r = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq
        egr_sqrt_cell #(.BIT_POS(SQRT_STEPS - 1 - i)) u_cell (
            .i_clk(i_clk), .i_en(adv), .i_s(w_sq[i]), .o_s(w_sq[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qpole[0] <= r_pole8;
            r_qbase[0] <= r_base8;
            r_qlx[0]   <= r_lx8;
            r_qly[0]   <= r_ly8;
            r_qz[0]    <= r_z8;
            for (int i = 1; i < SQRT_STEPS; i++) begin
                r_qpole[i] <= r_qpole[i-1];
                r_qbase[i] <= r_qbase[i-1];
                r_qlx[i]   <= r_qlx[i-1];
                r_qly[i]   <= r_qly[i-1];
                r_qz[i]    <= r_qz[i-1];
            end
        end
    end

    // ---------------- atan2 cell chains: longitude and latitude ----------------
    t_cvec w_vec [2][S+1];
    logic  r_vpole [S];
    logic  r_vbase [S];

    assign w_vec[0][0].x = r_qlx[SQRT_STEPS-1];
    assign w_vec[0][0].y = r_qly[SQRT_STEPS-1];
    assign w_vec[0][0].a = '0;
    assign w_vec[1][0].x = VW'(w_sq[SQRT_STEPS].r[30:0]);
    assign w_vec[1][0].y = VW'(r_qz[SQRT_STEPS-1]);
    assign w_vec[1][0].a = '0;

    for (genvar j = 0; j < 2; j++) begin : g_vec
        for (genvar i = 0; i < S; i++) begin : g_cell
            egr_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_cell (
                .i_clk(i_clk), .i_en(adv), .i_v(w_vec[j][i]), .o_v(w_vec[j][i+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vpole[0] <= r_qpole[SQRT_STEPS-1];
            r_vbase[0] <= r_qbase[SQRT_STEPS-1];
            for (int i = 1; i < S; i++) begin
                r_vpole[i] <= r_vpole[i-1];
                r_vbase[i] <= r_vbase[i-1];
            end
        end
    end

    // ---------------- turns to degrees ----------------
    logic [31:0]        r_t9;
    logic               r_pole9;
    logic               r_lneg9;
    logic [VW-1:0]      r_lmag9;
    logic [40:0]        n_lon_raw;
    logic [42:0]        n_lat_raw;
    logic [28:0]        r_lon_out;
    logic signed [27:0] r_lat_out;
    logic signed [VW-1:0] n_lat_ang;

    assign n_lat_ang = w_vec[1][S].a;
    assign n_lon_raw = ((41'(r_t9) * 41'd360) + HALF_LON) >> SH_OUT;
    assign n_lat_raw = ((43'(r_lmag9) * 43'd360) + HALF_LAT) >> SH_OUT;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // pole: longitude forced to zero; base adds half a turn
            r_t9    <= r_vpole[S-1] ? '0
                       : {w_vec[0][S].a[31] ^ r_vbase[S-1], w_vec[0][S].a[30:0]};
            r_pole9 <= r_vpole[S-1];
            r_lneg9 <= n_lat_ang[VW-1];
            r_lmag9 <= n_lat_ang[VW-1] ? VW'(-n_lat_ang) : VW'(n_lat_ang);
            // exactly 360 degrees wraps to zero
            r_lon_out <= (n_lon_raw >= FULL) ? 29'(n_lon_raw - FULL) : n_lon_raw[28:0];
            r_lat_out <= r_lneg9 ? -n_lat_raw[27:0] : n_lat_raw[27:0];
        end
    end

    assign o_out.lon_out = r_lon_out;
    assign o_out.lat_out = r_lat_out;

    // ---------------- checks ----------------
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid straight after reset");

    a_lon_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (ANGLE_FRACTION_BITS > 20) || (o_out.lon_out < FULL29))
        else $error("longitude not wrapped into a full turn");

    a_pole_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_vld[L-2] && r_pole9 |=> o_out.lon_out == '0)
        else $error("pole longitude not zero");

endmodule
`default_nettype wire

FILE: hw/rtl/egr_cordic_cell.sv
`default_nettype none
module egr_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  egr_pkg::t_cvec i_v,
    output egr_pkg::t_cvec o_v
);
    import egr_pkg::*;

    localparam logic signed [VW-1:0] ATAN = VW'(egr_atan(STAGE));

    logic signed [VW-1:0] xs, ys;
    logic                 ccw;
    t_cvec                n_v;
    t_cvec                r_v;

    assign xs  = i_v.x >>> STAGE;
    assign ys  = i_v.y >>> STAGE;
    // rotation steers on residual angle, vectoring on sign of y
    assign ccw = VECTORING ? i_v.y[VW-1] : !i_v.a[VW-1];

    always_comb begin
        if (ccw) begin
            n_v.x = i_v.x - ys;
            n_v.y = i_v.y + xs;
            n_v.a = i_v.a - ATAN;
        end else begin
            n_v.x = i_v.x + ys;
            n_v.y = i_v.y - xs;
            n_v.a = i_v.a + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_v <= n_v;
    end

    assign o_v = r_v;
endmodule
`default_nettype wire

FILE: hw/rtl/egr_sqrt_cell.sv
`default_nettype none
module egr_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  egr_pkg::t_sqrt i_s,
    output egr_pkg::t_sqrt o_s
);
    import egr_pkg::*;

    localparam logic [SQW-1:0] ONE_BIT = SQW'(1) << (2 * BIT_POS);

    logic [SQW:0] trial;
    t_sqrt        n_s;
    t_sqrt        r_s;

    assign trial = {1'b0, i_s.r} + {1'b0, ONE_BIT};

    always_comb begin
        if ({1'b0, i_s.v} >= trial) begin
            n_s.v = i_s.v - trial[SQW-1:0];
            n_s.r = (i_s.r >> 1) + ONE_BIT;
        end else begin
            n_s.v = i_s.v;
            n_s.r = i_s.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_s <= n_s;
    end

    assign o_s = r_s;
endmodule
`default_nettype wire
